>>> rtl/core/range_hazard_barrier_tracker_assert.svh
// Assertion macros shared by the range hazard barrier tracker RTL.
`ifndef RANGE_HAZARD_BARRIER_TRACKER_ASSERT_SVH
`define RANGE_HAZARD_BARRIER_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RHBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RHBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rhbt_pkg.sv
// Shared types and constants of the range hazard barrier tracker.
package rhbt_pkg;

    localparam int FUNC_W  = 2;
    localparam int TAG_W   = 16;
    localparam int OFS_W   = 32;
    localparam int TOTAL_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_ACCESS    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNTRACKED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH     = 2'd2;

    // One recorded or pending buffer access.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [OFS_W-1:0] lo;
        logic [OFS_W-1:0] hi;
        logic             wr;
    } entry_t;

endpackage

>>> rtl/core/rhbt_cmp.sv
// Hazard compare unit: one access against one recorded range.
module rhbt_cmp
(
    input  rhbt_pkg::entry_t access,
    input  rhbt_pkg::entry_t stored,
    output logic             hit
);

    logic same_tag;
    logic any_write;
    logic overlap;

    // Half-open ranges overlap when each starts before the other ends.
    assign same_tag  = (access.tag == stored.tag);
    assign any_write = access.wr | stored.wr;
    assign overlap   = (access.lo < stored.hi) && (stored.lo < access.hi);
    assign hit       = same_tag && any_write && overlap;

endmodule

>>> rtl/core/rhbt_table.sv
// Range table memory: one write port and one registered read port.
module rhbt_table
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  rhbt_pkg::entry_t     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output rhbt_pkg::entry_t     rdata
);

    rhbt_pkg::entry_t entry_mem [DEPTH];
    rhbt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= entry_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/range_hazard_barrier_tracker.sv
// Top level of the range hazard barrier tracker: sequencer, run buffer and counters.
//
// The input channel (in_valid/in_ready) carries one transaction per buffer access,
// untracked dispatch or batch flush, selected by func. Accesses of one dispatch come
// one after another; last_access marks the transaction that closes the dispatch.
// The output channel (out_valid/out_ready) carries one transaction per completed
// dispatch: the barrier decision, the elided flag, the table fill after the append
// and the two wrapping running totals. Flushes and non-final accesses give none.
// Each access walks the recorded ranges through one shared compare unit fed by the
// table's single registered read port, one entry per cycle, stopping early once a
// conflict is known. A final access then passes through a decision state, an append
// state that writes the pending ranges one by one into the table, and an emit state
// that loads the output register. Untracked dispatches go straight to the emit
// state; flushes complete in the idle state.
// The block takes one transaction at a time and is ready only while idle.
// A finished result sits in the output register while the next transaction is
// taken; if the receiver still stalls when another result is due, the sequencer
// waits for the output register to drain. Reset empties the table, the pending
// run and the batch and zeroes the totals; table entries are not cleared, since
// only entries below the fill count are ever read.
module range_hazard_barrier_tracker
#(
    parameter int TABLE_DEPTH  = 32,
    parameter int MAX_BINDINGS = 6
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rhbt_pkg::FUNC_W-1:0]          func,
    input  logic [rhbt_pkg::TAG_W-1:0]           buffer_tag,
    input  logic [rhbt_pkg::OFS_W-1:0]           range_lo,
    input  logic [rhbt_pkg::OFS_W-1:0]           range_hi,
    input  logic                                 is_write,
    input  logic                                 last_access,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 barrier,
    output logic                                 elided,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     table_fill,
    output logic [rhbt_pkg::TOTAL_W-1:0]         barrier_total,
    output logic [rhbt_pkg::TOTAL_W-1:0]         elided_total
);

    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW  = $clog2(MAX_BINDINGS + 1);
    localparam int PIW = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
    localparam int SW  = CW + 1;
    localparam int TW  = rhbt_pkg::TOTAL_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FINAL  = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    // Control state.
    logic [2:0]    state_reg,        state_next;
    logic [CW-1:0] table_count_reg,  table_count_next;
    logic [PW-1:0] pend_count_reg,   pend_count_next;
    logic          conflict_reg,     conflict_next;
    logic          batch_reg,        batch_next;
    logic [TW-1:0] barrier_cnt_reg,  barrier_cnt_next;
    logic [TW-1:0] elided_cnt_reg,   elided_cnt_next;
    logic [CW-1:0] scan_idx_reg,     scan_idx_next;
    logic          rd_pend_reg,      rd_pend_next;
    logic [PW-1:0] app_idx_reg,      app_idx_next;
    logic          out_valid_reg,    out_valid_next;

    // Payload state.
    rhbt_pkg::entry_t cur_reg,       cur_next;
    logic             last_reg,      last_next;
    logic             res_bar_reg,   res_bar_next;
    logic             res_eli_reg,   res_eli_next;
    logic             barrier_reg,   barrier_next;
    logic             elided_reg,    elided_next;
    logic [CW-1:0]    fill_reg,      fill_next;
    logic [TW-1:0]    bar_tot_reg,   bar_tot_next;
    logic [TW-1:0]    eli_tot_reg,   eli_tot_next;
    rhbt_pkg::entry_t pend_reg [MAX_BINDINGS];
    logic             pend_we;

    // Table and compare unit hookup.
    rhbt_pkg::entry_t in_entry;
    rhbt_pkg::entry_t mem_rdata;
    rhbt_pkg::entry_t mem_wdata;
    logic             mem_we;
    logic             mem_re;
    logic             cmp_hit;
    logic             in_fire;
    logic             out_free;
    logic             overflow;

    assign in_entry.tag = buffer_tag;
    assign in_entry.lo  = range_lo;
    assign in_entry.hi  = range_hi;
    assign in_entry.wr  = is_write;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // The pending run would not fit behind the recorded ranges.
    assign overflow = ((SW'(table_count_reg) + SW'(pend_count_reg)) > SW'(TABLE_DEPTH));

    assign mem_wdata = pend_reg[app_idx_reg[PIW-1:0]];

    rhbt_table
    #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    )
    u_table
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (table_count_reg[AW-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    rhbt_cmp u_cmp
    (
        .access (cur_reg),
        .stored (mem_rdata),
        .hit    (cmp_hit)
    );

    always_comb
    begin
        state_next       = state_reg;
        table_count_next = table_count_reg;
        pend_count_next  = pend_count_reg;
        conflict_next    = conflict_reg;
        batch_next       = batch_reg;
        barrier_cnt_next = barrier_cnt_reg;
        elided_cnt_next  = elided_cnt_reg;
        scan_idx_next    = scan_idx_reg;
        rd_pend_next     = 1'b0;
        app_idx_next     = app_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cur_next         = cur_reg;
        last_next        = last_reg;
        res_bar_next     = res_bar_reg;
        res_eli_next     = res_eli_reg;
        barrier_next     = barrier_reg;
        elided_next      = elided_reg;
        fill_next        = fill_reg;
        bar_tot_next     = bar_tot_reg;
        eli_tot_next     = eli_tot_reg;
        pend_we          = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (func)
                        rhbt_pkg::FUNC_ACCESS:
                        begin
                            // A table left over from an ended batch counts as empty.
                            if (!batch_reg)
                            begin
                                table_count_next = '0;
                            end
                            cur_next  = in_entry;
                            last_next = last_access;
                            if (pend_count_reg < PW'(MAX_BINDINGS))
                            begin
                                pend_we         = 1'b1;
                                pend_count_next = pend_count_reg + PW'(1);
                            end
                            else
                            begin
                                conflict_next = 1'b1;
                            end
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        rhbt_pkg::FUNC_UNTRACKED:
                        begin
                            pend_count_next  = '0;
                            conflict_next    = 1'b0;
                            res_bar_next     = batch_reg;
                            res_eli_next     = 1'b0;
                            if (batch_reg)
                            begin
                                barrier_cnt_next = barrier_cnt_reg + TW'(1);
                            end
                            table_count_next = '0;
                            batch_next       = 1'b1;
                            state_next       = ST_EMIT;
                        end
                        rhbt_pkg::FUNC_FLUSH:
                        begin
                            pend_count_next  = '0;
                            conflict_next    = 1'b0;
                            table_count_next = '0;
                            batch_next       = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Compare the entry read last cycle while the next one is fetched.
                if (rd_pend_reg && cmp_hit)
                begin
                    conflict_next = 1'b1;
                end
                if ((scan_idx_reg < table_count_reg) && !conflict_reg &&
                    !(rd_pend_reg && cmp_hit))
                begin
                    mem_re        = 1'b1;
                    rd_pend_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                res_bar_next = 1'b0;
                res_eli_next = 1'b0;
                if (batch_reg)
                begin
                    if (conflict_reg || overflow)
                    begin
                        res_bar_next     = 1'b1;
                        barrier_cnt_next = barrier_cnt_reg + TW'(1);
                        table_count_next = '0;
                    end
                    else
                    begin
                        res_eli_next    = 1'b1;
                        elided_cnt_next = elided_cnt_reg + TW'(1);
                    end
                end
                batch_next   = 1'b1;
                app_idx_next = '0;
                state_next   = ST_APPEND;
            end
            ST_APPEND:
            begin
                if ((app_idx_reg < pend_count_reg) &&
                    (table_count_reg < CW'(TABLE_DEPTH)))
                begin
                    mem_we           = 1'b1;
                    table_count_next = table_count_reg + CW'(1);
                    app_idx_next     = app_idx_reg + PW'(1);
                end
                else
                begin
                    pend_count_next = '0;
                    conflict_next   = 1'b0;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    barrier_next   = res_bar_reg;
                    elided_next    = res_eli_reg;
                    fill_next      = table_count_reg;
                    bar_tot_next   = barrier_cnt_reg;
                    eli_tot_next   = elided_cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            table_count_reg <= '0;
            pend_count_reg  <= '0;
            conflict_reg    <= 1'b0;
            batch_reg       <= 1'b0;
            barrier_cnt_reg <= '0;
            elided_cnt_reg  <= '0;
            scan_idx_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            app_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            table_count_reg <= table_count_next;
            pend_count_reg  <= pend_count_next;
            conflict_reg    <= conflict_next;
            batch_reg       <= batch_next;
            barrier_cnt_reg <= barrier_cnt_next;
            elided_cnt_reg  <= elided_cnt_next;
            scan_idx_reg    <= scan_idx_next;
            rd_pend_reg     <= rd_pend_next;
            app_idx_reg     <= app_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        res_bar_reg <= res_bar_next;
        res_eli_reg <= res_eli_next;
        barrier_reg <= barrier_next;
        elided_reg  <= elided_next;
        fill_reg    <= fill_next;
        bar_tot_reg <= bar_tot_next;
        eli_tot_reg <= eli_tot_next;
        if (pend_we)
        begin
            pend_reg[pend_count_reg[PIW-1:0]] <= in_entry;
        end
    end

    assign out_valid     = out_valid_reg;
    assign barrier       = barrier_reg;
    assign elided        = elided_reg;
    assign table_fill    = fill_reg;
    assign barrier_total = bar_tot_reg;
    assign elided_total  = eli_tot_reg;

`include "range_hazard_barrier_tracker_assert.svh"

    // The fill count never runs past the table.
    `RHBT_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, table_count_reg <= CW'(TABLE_DEPTH), "table fill exceeds depth")

    // The pending run never holds more than the binding limit.
    `RHBT_ASSERT_NOW(a_pend_bound, clk, rst_n, 1'b1, pend_count_reg <= PW'(MAX_BINDINGS), "pending run exceeds limit")

    // Outside a batch no recorded range may stay live.
    `RHBT_ASSERT_NOW(a_batch_empty, clk, rst_n, !batch_reg, table_count_reg == '0, "ranges recorded outside a batch")

    // A result loaded in the emit state is offered on the next cycle.
    `RHBT_ASSERT_NEXT(a_emit_shown, clk, rst_n, (state_reg == ST_EMIT) && out_free, out_valid_reg && (state_reg == ST_IDLE), "result not offered after emit")

endmodule

>>> verif/tb.sv
// Self-checking testbench for the range hazard barrier tracker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhbt_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int MAX_BINDINGS = 6;
    localparam int FILL_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_CAP   = 40;
    localparam longint RUN_LIMIT_NS = 20_000_000;

    // The package leaves the fourth func code unnamed; the block ignores it.
    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

    // One input transaction as it appears on the input channel.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        entry_t            acc;
        logic              last;
    } cmd_t;

    // One dispatch result, field order matching the output ports.
    typedef struct packed {
        logic               barrier;
        logic               elided;
        logic [FILL_W-1:0]  fill;
        logic [TOTAL_W-1:0] barrier_total;
        logic [TOTAL_W-1:0] elided_total;
    } verdict_t;

    // Tracks the recorded ranges and the pending run, and predicts each dispatch verdict.
    class barrier_scoreboard;
        entry_t             recorded[TABLE_DEPTH];
        entry_t             run_buf[MAX_BINDINGS];
        int unsigned        fill;
        int unsigned        run_len;
        bit                 run_conflict;
        bit                 batch_open;
        logic [TOTAL_W-1:0] barriers;
        logic [TOTAL_W-1:0] elisions;
        verdict_t           expected_verdicts[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        peak_fill;

        function new();
            fill         = 0;
            run_len      = 0;
            run_conflict = 1'b0;
            batch_open   = 1'b0;
            barriers     = '0;
            elisions     = '0;
            mismatches   = 0;
            checked      = 0;
            peak_fill    = 0;
        endfunction

        // Same tag, overlapping half-open ranges and at least one writer.
        function bit hits_recorded(entry_t a);
            for (int unsigned d = 0; d < fill; d++)
            begin
                if (recorded[d].tag == a.tag && (recorded[d].wr || a.wr) &&
                    a.lo < recorded[d].hi && recorded[d].lo < a.hi)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(cmd_t c);
            verdict_t v;
            v = '0;
            if (c.func == FUNC_RESERVED)
                return;
            if (c.func == FUNC_FLUSH)
            begin
                run_len      = 0;
                run_conflict = 1'b0;
                fill         = 0;
                batch_open   = 1'b0;
                return;
            end
            if (!batch_open)
                fill = 0;
            if (c.func == FUNC_UNTRACKED)
            begin
                run_len      = 0;
                run_conflict = 1'b0;
                if (batch_open)
                begin
                    v.barrier = 1'b1;
                    barriers++;
                end
                fill = 0;
            end
            else
            begin
                if (!run_conflict && hits_recorded(c.acc))
                    run_conflict = 1'b1;
                if (run_len < MAX_BINDINGS)
                begin
                    run_buf[run_len] = c.acc;
                    run_len++;
                end
                else
                    run_conflict = 1'b1;
                if (!c.last)
                    return;
                if (fill + run_len > TABLE_DEPTH)
                    run_conflict = 1'b1;
                if (batch_open)
                begin
                    if (run_conflict)
                    begin
                        v.barrier = 1'b1;
                        barriers++;
                        fill = 0;
                    end
                    else
                    begin
                        v.elided = 1'b1;
                        elisions++;
                    end
                end
                for (int unsigned i = 0; i < run_len && fill < TABLE_DEPTH; i++)
                begin
                    recorded[fill] = run_buf[i];
                    fill++;
                end
                run_len      = 0;
                run_conflict = 1'b0;
            end
            batch_open      = 1'b1;
            v.fill          = FILL_W'(fill);
            v.barrier_total = barriers;
            v.elided_total  = elisions;
            if (fill > peak_fill)
                peak_fill = fill;
            expected_verdicts.push_back(v);
        endfunction

        function void compare_field(string what, logic [TOTAL_W-1:0] want,
                                    logic [TOTAL_W-1:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, what, want, got);
            end
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            checked++;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d %0d",
                             $time, got.barrier, got.elided, got.fill,
                             got.barrier_total, got.elided_total);
                return;
            end
            want = expected_verdicts.pop_front();
            compare_field("barrier", want.barrier, got.barrier);
            compare_field("elided", want.elided, got.elided);
            compare_field("table_fill", want.fill, got.fill);
            compare_field("barrier_total", want.barrier_total, got.barrier_total);
            compare_field("elided_total", want.elided_total, got.elided_total);
        endfunction

        function int unsigned outstanding();
            return expected_verdicts.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func;
    logic [TAG_W-1:0]         buffer_tag;
    logic [OFS_W-1:0]         range_lo;
    logic [OFS_W-1:0]         range_hi;
    logic                     is_write;
    logic                     last_access;
    logic                     out_valid;
    logic                     out_ready;
    logic                     barrier;
    logic                     elided;
    logic [FILL_W-1:0]        table_fill;
    logic [TOTAL_W-1:0]       barrier_total;
    logic [TOTAL_W-1:0]       elided_total;

    barrier_scoreboard sb;
    int unsigned       send_idle_pct;
    int unsigned       recv_idle_pct;
    int unsigned       sent_items;

    range_hazard_barrier_tracker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_BINDINGS(MAX_BINDINGS)
    ) dut (.*);

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // The receiver decides its ready once per cycle, at the falling edge.
    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_idle_pct);

    // Results are taken at the rising edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({barrier, elided, table_fill, barrier_total, elided_total});
    end

    // Drives one transaction: optional idle cycles first, then valid is held with a
    // stable payload until the edge at which the block takes it.
    task automatic send_cmd(input cmd_t c);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    = 1'b1;
        func        = c.func;
        buffer_tag  = c.acc.tag;
        range_lo    = c.acc.lo;
        range_hi    = c.acc.hi;
        is_write    = c.acc.wr;
        last_access = c.last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(c);
        if (c.func != FUNC_RESERVED)
            sent_items++;
    endtask

    // Calm accesses use wide random tags, so they rarely conflict and let the table fill.
    function automatic entry_t random_access(bit calm);
        entry_t      a;
        int unsigned shape;
        shape = $urandom_range(99);
        if (calm || $urandom_range(1) == 1)
            a.tag = TAG_W'($urandom());
        else
            a.tag = TAG_W'($urandom_range(3));
        if (shape < 6)
        begin
            a.lo = $urandom();
            a.hi = $urandom();
        end
        else if (shape < 12)
        begin
            // Empty or inverted range.
            a.lo = $urandom_range(1023);
            a.hi = $urandom_range(a.lo);
        end
        else
        begin
            a.lo = $urandom_range(1023);
            a.hi = a.lo + $urandom_range(1, 128);
        end
        a.wr = ($urandom_range(99) < 30);
        return a;
    endfunction

    task automatic send_access(input logic [TAG_W-1:0] tag, input logic [OFS_W-1:0] lo,
                               input logic [OFS_W-1:0] hi, input logic wr, input logic last);
        cmd_t c;
        c.func   = FUNC_ACCESS;
        c.acc.tag = tag;
        c.acc.lo  = lo;
        c.acc.hi  = hi;
        c.acc.wr  = wr;
        c.last    = last;
        send_cmd(c);
    endtask

    // Untracked dispatch, flush or unknown code, with random don't-care payload.
    task automatic send_control(input logic [FUNC_W-1:0] code);
        cmd_t c;
        c.func = code;
        c.acc  = random_access(1'b1);
        c.last = 1'($urandom_range(1));
        send_cmd(c);
    endtask

    task automatic run_directed();
        // Full-span write, then a read inside it: the read must take a barrier.
        send_access(16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_access(16'h0000, 32'h0000_0010, 32'h0000_0020, 1'b0, 1'b1);
        // Empty range at the top of the address space and an inverted range never overlap.
        send_access(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_access(16'h0000, 32'h0000_0030, 32'h0000_0010, 1'b1, 1'b1);
        send_control(FUNC_RESERVED);
        // One access more than the run buffer holds forces a barrier.
        for (int k = 0; k <= MAX_BINDINGS; k++)
            send_access(16'h1234, 32'(k * 16), 32'(k * 16 + 8), 1'b0, k == MAX_BINDINGS);
        // Run cut short by an untracked dispatch, then by a flush.
        send_access(16'h0005, 32'h0, 32'h8, 1'b1, 1'b0);
        send_control(FUNC_UNTRACKED);
        send_access(16'h0005, 32'h0, 32'h8, 1'b0, 1'b1);
        send_access(16'h0006, 32'h0, 32'h8, 1'b1, 1'b0);
        send_control(FUNC_FLUSH);
        // Untracked dispatch in an empty batch takes no barrier.
        send_control(FUNC_UNTRACKED);
        send_control(FUNC_FLUSH);
        send_access(16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    // Mostly well-formed dispatches; some runs are too long, some are cut off by an
    // untracked dispatch or a flush, and unknown codes are mixed in.
    task automatic run_random(input int unsigned goal);
        int unsigned roll;
        int unsigned len;
        bit          calm;
        bit          broken;
        entry_t      a;
        calm = 1'b0;
        while (sent_items < goal)
        begin
            if ($urandom_range(99) < 12)
                calm = !calm;
            roll = $urandom_range(99);
            if (roll < 4)
                send_control(FUNC_UNTRACKED);
            else if (roll < 7)
                send_control(FUNC_FLUSH);
            else if (roll < 9)
                send_control(FUNC_RESERVED);
            else
            begin
                if ($urandom_range(99) < 8)
                    len = $urandom_range(MAX_BINDINGS + 1, MAX_BINDINGS + 3);
                else
                    len = $urandom_range(1, MAX_BINDINGS);
                broken = ($urandom_range(99) < 6);
                if (broken)
                    len = $urandom_range(1, len);
                for (int unsigned k = 0; k < len; k++)
                begin
                    if ($urandom_range(99) < 2)
                        send_control(FUNC_RESERVED);
                    a = random_access(calm);
                    send_access(a.tag, a.lo, a.hi, a.wr, !broken && k == len - 1);
                end
                if (broken)
                    send_control($urandom_range(1) == 1 ? FUNC_UNTRACKED : FUNC_FLUSH);
            end
        end
    endtask

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout: the run did not complete within the time limit.");
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        sb            = new();
        sent_items    = 0;
        send_idle_pct = 38;
        recv_idle_pct = 64;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_ACCESS;
        buffer_tag    = '0;
        range_lo      = '0;
        range_hi      = '0;
        is_write      = 1'b0;
        last_access   = 1'b0;
        out_ready     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random(sent_items + 360);
        send_idle_pct = 64;
        recv_idle_pct = 38;
        run_random(sent_items + 360);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(sent_items + 360);

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        // Any late extra result would show up here as an unexpected one.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d transactions accepted, %0d dispatch results checked.",
                 sent_items, sb.checked);
        $display("Summary: %0d barriers, %0d elided, peak table fill %0d of %0d.",
                 sb.barriers, sb.elisions, sb.peak_fill, TABLE_DEPTH);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
